// ===== rtl/core/dwc_pkg.sv =====
// ----------------------------------------------------------------------------
// dwc_pkg
// Shared constants and codes for the depthwise convolution block.
// ----------------------------------------------------------------------------
package dwc_pkg;

    localparam int MAX_DIM   = 128;
    localparam int KERNEL_H  = 3;
    localparam int KERNEL_W  = 3;
    localparam int NTAPS     = KERNEL_H * KERNEL_W;

    localparam int DIM_W     = $clog2(MAX_DIM);
    localparam int ADDR_W    = 2 * DIM_W;
    localparam int DEPTH     = MAX_DIM * MAX_DIM;
    localparam int TAP_IDX_W = (NTAPS > 1) ? $clog2(NTAPS) : 1;
    localparam int KH_W      = $clog2(KERNEL_H + 1);
    localparam int KW_W      = $clog2(KERNEL_W + 1);
    // signed window coordinate: row*stride + kernel offset - pad
    localparam int POS_W     = 12;

    typedef enum logic [1:0] {
        CMD_TAP     = 2'd0,
        CMD_BIAS    = 2'd1,
        CMD_PIXEL   = 2'd2,
        CMD_COMPUTE = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        REG_IN_HEIGHT  = 3'd0,
        REG_IN_WIDTH   = 3'd1,
        REG_OUT_HEIGHT = 3'd2,
        REG_OUT_WIDTH  = 3'd3,
        REG_PAD        = 3'd4,
        REG_STRIDE     = 3'd5,
        REG_SHIFT      = 3'd6,
        REG_MODE       = 3'd7
    } reg_idx_t;

endpackage

// ===== rtl/core/dwc_ram.sv =====
// ----------------------------------------------------------------------------
// dwc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module dwc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/depthwise_conv_int8_requant.sv =====
// ----------------------------------------------------------------------------
// depthwise_conv_int8_requant
// Int8 depthwise 2D convolution of one channel plane with bias, shift and
// clamp requantization.
// Flow: a compute transaction steps through S_RUN (one plane read and one
// multiply-accumulate per kernel tap through the single RAM read port),
// S_DRAIN, S_BIAS (bias) and S_FINISH (shift/clamp). No new transaction is
// taken until its result is issued; one load per cycle while idle.
// Reset: async, clears control, bias and config to defaults; pixel and tap
// stores stay undefined until written.
// ----------------------------------------------------------------------------
module depthwise_conv_int8_requant (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         command,
    input  logic [6:0]         row,
    input  logic [6:0]         col,
    input  logic [3:0]         tap_index,
    input  logic signed [7:0]  sample,
    input  logic signed [31:0] bias_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [7:0]  out_value,
    output logic               last,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [7:0]         cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_BIAS,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;

    logic [7:0] in_height_reg, in_width_reg, out_height_reg, out_width_reg;
    logic [2:0] pad_reg, stride_reg;
    logic [4:0] shift_reg;
    logic [1:0] mode_reg;
    logic [31:0] bias_reg, bias_next;

    logic [7:0] taps_reg [dwc_pkg::NTAPS];

    logic [dwc_pkg::POS_W-1:0] base_r_reg, base_r_next, base_c_reg, base_c_next;
    logic [dwc_pkg::KH_W-1:0] kh_reg, kh_next;
    logic [dwc_pkg::KW_W-1:0] kw_reg, kw_next;
    logic [dwc_pkg::TAP_IDX_W-1:0] tap_cnt_reg, tap_cnt_next;
    logic pend_reg, pend_next;
    logic hit_reg, hit_next;
    logic [7:0] tap_q_reg, tap_q_next;
    logic [31:0] acc_reg, acc_next;
    logic last_pend_reg, last_pend_next;
    logic out_valid_reg, out_valid_next;
    logic [7:0] out_value_reg, out_value_next;
    logic last_reg, last_next;

    logic in_accept;
    logic [dwc_pkg::POS_W-1:0] ih, iw;
    logic [7:0] h_lim, w_lim;
    logic in_window;
    logic ram_we, ram_re;
    logic [dwc_pkg::ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [7:0] ram_q;
    logic signed [15:0] prod;
    logic signed [31:0] shifted;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign last      = last_reg;

    assign h_lim = (in_height_reg > 8'(dwc_pkg::MAX_DIM)) ? 8'(dwc_pkg::MAX_DIM)
                                                          : in_height_reg;
    assign w_lim = (in_width_reg > 8'(dwc_pkg::MAX_DIM)) ? 8'(dwc_pkg::MAX_DIM)
                                                         : in_width_reg;

    assign ih = base_r_reg + dwc_pkg::POS_W'(kh_reg);
    assign iw = base_c_reg + dwc_pkg::POS_W'(kw_reg);
    assign in_window = !ih[dwc_pkg::POS_W-1] && !iw[dwc_pkg::POS_W-1]
                    && (ih[dwc_pkg::POS_W-2:0] < (dwc_pkg::POS_W-1)'(h_lim))
                    && (iw[dwc_pkg::POS_W-2:0] < (dwc_pkg::POS_W-1)'(w_lim));

    assign ram_we    = in_accept && (command == dwc_pkg::CMD_PIXEL)
                    && (32'(row) < dwc_pkg::MAX_DIM) && (32'(col) < dwc_pkg::MAX_DIM);
    assign ram_waddr = {row[dwc_pkg::DIM_W-1:0], col[dwc_pkg::DIM_W-1:0]};
    assign ram_re    = (state_reg == S_RUN) && in_window;
    assign ram_raddr = {ih[dwc_pkg::DIM_W-1:0], iw[dwc_pkg::DIM_W-1:0]};

    dwc_ram #(
        .WIDTH(8),
        .DEPTH(dwc_pkg::DEPTH)
    ) u_plane (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(sample),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_q)
    );

    assign prod    = $signed(ram_q) * $signed(tap_q_reg);
    assign shifted = $signed(acc_reg) >>> shift_reg;

    always_comb
    begin
        state_next     = state_reg;
        bias_next      = bias_reg;
        base_r_next    = base_r_reg;
        base_c_next    = base_c_reg;
        kh_next        = kh_reg;
        kw_next        = kw_reg;
        tap_cnt_next   = tap_cnt_reg;
        pend_next      = 1'b0;
        hit_next       = hit_reg;
        tap_q_next     = tap_q_reg;
        acc_next       = acc_reg;
        last_pend_next = last_pend_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_value_next = out_value_reg;
        last_next      = last_reg;

        // multiply-accumulate stage, one tap behind the read
        if (pend_reg && hit_reg)
        begin
            acc_next = acc_reg + 32'(prod);
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (command == dwc_pkg::CMD_BIAS)
                    begin
                        bias_next = bias_value;
                    end
                    if (command == dwc_pkg::CMD_COMPUTE)
                    begin
                        base_r_next = dwc_pkg::POS_W'(row) * dwc_pkg::POS_W'(stride_reg)
                                    - dwc_pkg::POS_W'(pad_reg);
                        base_c_next = dwc_pkg::POS_W'(col) * dwc_pkg::POS_W'(stride_reg)
                                    - dwc_pkg::POS_W'(pad_reg);
                        kh_next        = '0;
                        kw_next        = '0;
                        tap_cnt_next   = '0;
                        acc_next       = '0;
                        last_pend_next = ((9'(row) + 9'd1) == 9'(out_height_reg))
                                      && ((9'(col) + 9'd1) == 9'(out_width_reg));
                        state_next     = S_RUN;
                    end
                end
            end
            S_RUN:
            begin
                pend_next  = 1'b1;
                hit_next   = in_window;
                tap_q_next = taps_reg[tap_cnt_reg];
                if (32'(tap_cnt_reg) == dwc_pkg::NTAPS - 1)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    tap_cnt_next = tap_cnt_reg + 1'b1;
                    if (32'(kw_reg) == dwc_pkg::KERNEL_W - 1)
                    begin
                        kw_next = '0;
                        kh_next = kh_reg + 1'b1;
                    end
                    else
                    begin
                        kw_next = kw_reg + 1'b1;
                    end
                end
            end
            S_DRAIN:
            begin
                state_next = S_BIAS;
            end
            S_BIAS:
            begin
                if (mode_reg[1])
                begin
                    acc_next = acc_reg + bias_reg;
                end
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    priority if (shifted >= 32'sd127)
                    begin
                        out_value_next = 8'sd127;
                    end
                    else if (mode_reg[0] && shifted < 32'sd0)
                    begin
                        out_value_next = 8'sd0;
                    end
                    else if (shifted < -32'sd128)
                    begin
                        out_value_next = -8'sd128;
                    end
                    else
                    begin
                        out_value_next = shifted[7:0];
                    end
                    last_next      = last_pend_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            in_height_reg  <= 8'd1;
            in_width_reg   <= 8'd1;
            out_height_reg <= 8'd1;
            out_width_reg  <= 8'd1;
            pad_reg        <= '0;
            stride_reg     <= 3'd1;
            shift_reg      <= '0;
            mode_reg       <= '0;
            bias_reg       <= '0;
            pend_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_value_reg  <= '0;
            last_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bias_reg      <= bias_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            out_value_reg <= out_value_next;
            last_reg      <= last_next;
            if (cfg_we)
            begin
                unique case (dwc_pkg::reg_idx_t'(cfg_index))
                    dwc_pkg::REG_IN_HEIGHT:  in_height_reg  <= cfg_data;
                    dwc_pkg::REG_IN_WIDTH:   in_width_reg   <= cfg_data;
                    dwc_pkg::REG_OUT_HEIGHT: out_height_reg <= cfg_data;
                    dwc_pkg::REG_OUT_WIDTH:  out_width_reg  <= cfg_data;
                    dwc_pkg::REG_PAD:        pad_reg        <= cfg_data[2:0];
                    dwc_pkg::REG_STRIDE:     stride_reg     <= cfg_data[2:0];
                    dwc_pkg::REG_SHIFT:      shift_reg      <= cfg_data[4:0];
                    dwc_pkg::REG_MODE:       mode_reg       <= cfg_data[1:0];
                    default:                 mode_reg       <= mode_reg;
                endcase
            end
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        base_r_reg    <= base_r_next;
        base_c_reg    <= base_c_next;
        kh_reg        <= kh_next;
        kw_reg        <= kw_next;
        tap_cnt_reg   <= tap_cnt_next;
        hit_reg       <= hit_next;
        tap_q_reg     <= tap_q_next;
        acc_reg       <= acc_next;
        last_pend_reg <= last_pend_next;
        if (in_accept && (command == dwc_pkg::CMD_TAP)
            && (32'(tap_index) < dwc_pkg::NTAPS))
        begin
            taps_reg[tap_index[dwc_pkg::TAP_IDX_W-1:0]] <= sample;
        end
    end

    a_compute_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && (command == dwc_pkg::CMD_COMPUTE) |=> state_reg == S_RUN)
        else $error("compute transaction did not start the tap loop");

    a_mac_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> $past(state_reg) == S_RUN)
        else $error("accumulate step without a tap read");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_FINISH)
        else $error("result raised outside finish step");

endmodule

// ===== verif/tb_depthwise_conv_int8_requant.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_depthwise_conv_int8_requant
// Self-checking bench for the int8 depthwise convolution block. A directed
// table covers loads, field extremes and fixed results. Randomized phases
// then reprogram the plane geometry and requantization between drained
// windows. Every compute result is checked in order against a prediction or a fixed expectation.
// ----------------------------------------------------------------------------
module tb_depthwise_conv_int8_requant;
    import dwc_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 20;
    localparam int RANDOM_ITEMS   = 1750;
    localparam int PRESET_COUNT   = 10;

    typedef struct packed {
        logic signed [7:0] value;
        logic              last;
    } conv_result_t;

    typedef struct {
        logic [7:0] in_h;
        logic [7:0] in_w;
        logic [7:0] out_h;
        logic [7:0] out_w;
        logic [2:0] pad;
        logic [2:0] stride;
        logic [4:0] shift;
        logic [1:0] mode;
    } conv_cfg_t;

    typedef struct {
        cmd_t               cmd;
        logic [6:0]         row;
        logic [6:0]         col;
        logic [3:0]         tap;
        logic signed [7:0]  smp;
        logic signed [31:0] bias;
        bit                 typed;
        conv_result_t       want;
    } stim_row_t;

    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               in_valid   = 1'b0;
    logic               in_stall;
    logic [1:0]         command    = CMD_TAP;
    logic [6:0]         row        = '0;
    logic [6:0]         col        = '0;
    logic [3:0]         tap_index  = '0;
    logic signed [7:0]  sample     = '0;
    logic signed [31:0] bias_value = '0;
    logic               out_valid;
    logic               out_stall  = 1'b0;
    logic signed [7:0]  out_value;
    logic               last;
    logic               cfg_we     = 1'b0;
    logic [2:0]         cfg_index  = REG_IN_HEIGHT;
    logic [7:0]         cfg_data   = '0;

    // fixed expectation travels with the transaction that carries it
    bit                 typed_pending = 1'b0;
    conv_result_t       typed_result  = '0;

    conv_cfg_t          cur_cfg;
    logic signed [7:0]  pixel_mem [MAX_DIM*MAX_DIM];
    bit                 pixel_loaded [MAX_DIM*MAX_DIM];
    logic signed [7:0]  tap_mem [NTAPS];
    logic signed [31:0] bias_q = '0;
    conv_result_t       expected_outputs [$];

    int mismatch_count = 0;
    int send_idle_pct  = 11;
    int recv_idle_pct  = 71;
    int quiet_cycles   = 0;
    int random_sent    = 0;

    depthwise_conv_int8_requant dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .command    (command),
        .row        (row),
        .col        (col),
        .tap_index  (tap_index),
        .sample     (sample),
        .bias_value (bias_value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_value  (out_value),
        .last       (last),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic conv_cfg_t make_cfg(input int ih, input int iw, input int oh,
                                           input int ow, input int p, input int s,
                                           input int sh, input int m);
        conv_cfg_t cfg;
        cfg.in_h   = ih;
        cfg.in_w   = iw;
        cfg.out_h  = oh;
        cfg.out_w  = ow;
        cfg.pad    = p;
        cfg.stride = s;
        cfg.shift  = sh;
        cfg.mode   = m;
        return cfg;
    endfunction

    function automatic stim_row_t stim_row(input cmd_t cmd, input int r, input int c,
                                           input int t, input int s, input int b,
                                           input bit typed, input int v, input bit l);
        stim_row_t sr;
        sr.cmd        = cmd;
        sr.row        = r;
        sr.col        = c;
        sr.tap        = t;
        sr.smp        = s;
        sr.bias       = b;
        sr.typed      = typed;
        sr.want.value = v;
        sr.want.last  = l;
        return sr;
    endfunction

    // true when window tap (kh, kw) of output (r, c) lands inside the plane
    function automatic bit window_pixel(input int r, input int c, input int kh,
                                        input int kw, output int idx);
        int h;
        int w;
        int ih;
        int iw;
        h  = (cur_cfg.in_h > MAX_DIM) ? MAX_DIM : int'(cur_cfg.in_h);
        w  = (cur_cfg.in_w > MAX_DIM) ? MAX_DIM : int'(cur_cfg.in_w);
        ih = r * int'(cur_cfg.stride) + kh - int'(cur_cfg.pad);
        iw = c * int'(cur_cfg.stride) + kw - int'(cur_cfg.pad);
        idx = ih * MAX_DIM + iw;
        return (ih >= 0 && iw >= 0 && ih < h && iw < w);
    endfunction

    function automatic conv_result_t conv_output(input int r, input int c);
        logic signed [31:0] acc;
        int                 idx;
        conv_result_t       res;
        acc = '0;
        for (int kh = 0; kh < KERNEL_H; kh++)
            for (int kw = 0; kw < KERNEL_W; kw++)
                if (window_pixel(r, c, kh, kw, idx))
                    acc = acc + pixel_mem[idx] * tap_mem[kh * KERNEL_W + kw];
        if (cur_cfg.mode[1])
            acc = acc + bias_q;
        acc = acc >>> cur_cfg.shift;
        if (acc > 127)
            acc = 127;
        if (cur_cfg.mode[0])
        begin
            if (acc < 0)
                acc = 0;
        end
        else if (acc < -128)
            acc = -128;
        res.value = acc[7:0];
        res.last  = (int'(cur_cfg.out_h) - 1 == r) && (int'(cur_cfg.out_w) - 1 == c);
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 100)
            $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    task automatic send_item(input cmd_t cmd, input logic [6:0] r, input logic [6:0] c,
                             input logic [3:0] t, input logic signed [7:0] s,
                             input logic signed [31:0] b, input bit typed,
                             input conv_result_t want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        command       <= cmd;
        row           <= r;
        col           <= c;
        tap_index     <= t;
        sample        <= s;
        bias_value    <= b;
        typed_pending <= typed;
        typed_result  <= want;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // loads any window pixel not yet written, then issues the compute
    task automatic send_compute(input logic [6:0] r, input logic [6:0] c);
        int idx;
        for (int kh = 0; kh < KERNEL_H; kh++)
            for (int kw = 0; kw < KERNEL_W; kw++)
                if (window_pixel(r, c, kh, kw, idx) && !pixel_loaded[idx])
                begin
                    pixel_loaded[idx] = 1'b1;
                    send_item(CMD_PIXEL, idx / MAX_DIM, idx % MAX_DIM, $urandom,
                              $urandom, $urandom, 1'b0, '0);
                    random_sent++;
                end
        send_item(CMD_COMPUTE, r, c, $urandom, $urandom, $urandom, 1'b0, '0);
        random_sent++;
    endtask

    // one edge first so the monitor has logged the last accepted transaction
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_outputs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [7:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic apply_config(input conv_cfg_t cfg);
        logic [7:0] noise;
        noise = $urandom;
        write_reg(REG_IN_HEIGHT, cfg.in_h);
        write_reg(REG_IN_WIDTH, cfg.in_w);
        write_reg(REG_OUT_HEIGHT, cfg.out_h);
        write_reg(REG_OUT_WIDTH, cfg.out_w);
        write_reg(REG_PAD, {noise[7:3], cfg.pad});
        write_reg(REG_STRIDE, {noise[4:0], cfg.stride});
        write_reg(REG_SHIFT, {noise[2:0], cfg.shift});
        write_reg(REG_MODE, {noise[5:0], cfg.mode});
        cfg_we <= 1'b0;
        cur_cfg = cfg;
    endtask

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            case (command)
                CMD_TAP:
                    if (tap_index < NTAPS)
                        tap_mem[tap_index] = sample;
                CMD_BIAS:
                    bias_q = bias_value;
                CMD_PIXEL:
                    pixel_mem[int'(row) * MAX_DIM + int'(col)] = sample;
                CMD_COMPUTE:
                    expected_outputs.push_back(typed_pending ? typed_result
                                                             : conv_output(row, col));
            endcase
        end
    end

    always @(posedge clk)
    begin : check_outputs
        conv_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_outputs.size() == 0)
                report_mismatch($sformatf("unexpected output %0d", out_value));
            else
            begin
                want = expected_outputs.pop_front();
                if (out_value !== want.value)
                    report_mismatch($sformatf("out_value %0d, expected %0d",
                                              out_value, want.value));
                if (last !== want.last)
                    report_mismatch($sformatf("last %b, expected %b", last, want.last));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        stim_row_t          directed_rows [$];
        conv_cfg_t          presets [PRESET_COUNT];
        conv_cfg_t          cfg;
        int                 phase;
        int                 pick;
        int                 h;
        int                 w;
        logic [6:0]         r;
        logic [6:0]         c;
        logic signed [31:0] b;

        cur_cfg = make_cfg(1, 1, 1, 1, 0, 1, 0, 0);

        presets[0] = make_cfg(4, 4, 4, 4, 1, 1, 7, 0);
        presets[1] = make_cfg(8, 8, 8, 8, 0, 1, 8, 3);
        presets[2] = make_cfg(128, 128, 128, 128, 7, 4, 31, 1);
        presets[3] = make_cfg(255, 200, 64, 64, 3, 2, 9, 2);
        presets[4] = make_cfg(0, 5, 3, 3, 1, 1, 0, 3);
        presets[5] = make_cfg(6, 6, 0, 0, 2, 0, 5, 1);
        presets[6] = make_cfg(10, 10, 2, 2, 0, 7, 6, 2);
        presets[7] = make_cfg(9, 9, 3, 3, 0, 5, 4, 0);
        presets[8] = make_cfg(1, 1, 1, 1, 0, 1, 0, 0);
        presets[9] = make_cfg(16, 3, 16, 3, 7, 6, 12, 3);

        // reset geometry: 1x1 plane, 1x1 output, no pad, stride 1
        directed_rows.push_back(stim_row(CMD_COMPUTE, 5, 5, 0, 0, 0, 1, 0, 0));
        directed_rows.push_back(stim_row(CMD_TAP, 0, 0, 0, -128, 0, 0, 0, 0));
        directed_rows.push_back(stim_row(CMD_TAP, 0, 0, 1, 127, 0, 0, 0, 0));
        directed_rows.push_back(stim_row(CMD_TAP, 0, 0, 2, -1, 0, 0, 0, 0));
        directed_rows.push_back(stim_row(CMD_TAP, 0, 0, 3, 1, 0, 0, 0, 0));
        directed_rows.push_back(stim_row(CMD_TAP, 0, 0, 4, 0, 0, 0, 0, 0));
        directed_rows.push_back(stim_row(CMD_TAP, 0, 0, 5, 64, 0, 0, 0, 0));
        directed_rows.push_back(stim_row(CMD_TAP, 0, 0, 6, -64, 0, 0, 0, 0));
        directed_rows.push_back(stim_row(CMD_TAP, 0, 0, 7, 100, 0, 0, 0, 0));
        directed_rows.push_back(stim_row(CMD_TAP, 0, 0, 8, -100, 0, 0, 0, 0));
        directed_rows.push_back(stim_row(CMD_TAP, 0, 0, 15, 127, 0, 0, 0, 0));
        directed_rows.push_back(stim_row(CMD_TAP, 0, 0, 9, 55, 0, 0, 0, 0));
        directed_rows.push_back(stim_row(CMD_PIXEL, 0, 0, 0, -128, 0, 0, 0, 0));
        directed_rows.push_back(stim_row(CMD_COMPUTE, 0, 0, 0, 0, 0, 1, 127, 1));
        directed_rows.push_back(stim_row(CMD_PIXEL, 0, 0, 0, 127, 0, 0, 0, 0));
        directed_rows.push_back(stim_row(CMD_COMPUTE, 0, 0, 0, 0, 0, 1, -128, 1));
        directed_rows.push_back(stim_row(CMD_BIAS, 0, 0, 0, 0, 32'h7FFFFFFF, 0, 0, 0));
        directed_rows.push_back(stim_row(CMD_BIAS, 0, 0, 0, 0, 32'h80000000, 0, 0, 0));
        directed_rows.push_back(stim_row(CMD_PIXEL, 127, 127, 15, 1, -1, 0, 0, 0));
        directed_rows.push_back(stim_row(CMD_COMPUTE, 127, 127, 0, 0, 0, 1, 0, 0));
        directed_rows.push_back(stim_row(CMD_PIXEL, 0, 0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(stim_row(CMD_COMPUTE, 0, 0, 0, 0, 0, 1, 0, 1));
        directed_rows.push_back(stim_row(CMD_PIXEL, 0, 1, 0, -1, 0, 0, 0, 0));
        directed_rows.push_back(stim_row(CMD_COMPUTE, 0, 0, 0, 0, 0, 0, 0, 0));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].cmd == CMD_PIXEL)
                pixel_loaded[int'(directed_rows[i].row) * MAX_DIM +
                             int'(directed_rows[i].col)] = 1'b1;
            send_item(directed_rows[i].cmd, directed_rows[i].row, directed_rows[i].col,
                      directed_rows[i].tap, directed_rows[i].smp, directed_rows[i].bias,
                      directed_rows[i].typed, directed_rows[i].want);
        end

        phase = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            wait_idle();
            if (phase < PRESET_COUNT)
                cfg = presets[phase];
            else
            begin
                cfg.in_h   = ($urandom_range(99) < 90) ? $urandom_range(1, 12)
                                                       : $urandom_range(255);
                cfg.in_w   = ($urandom_range(99) < 90) ? $urandom_range(1, 12)
                                                       : $urandom_range(255);
                pick       = $urandom_range(99);
                cfg.out_h  = (pick < 10) ? 0 : (pick < 20) ? $urandom_range(255)
                                                           : $urandom_range(1, 8);
                pick       = $urandom_range(99);
                cfg.out_w  = (pick < 10) ? 0 : (pick < 20) ? $urandom_range(255)
                                                           : $urandom_range(1, 8);
                cfg.pad    = ($urandom_range(99) < 60) ? $urandom_range(2)
                                                       : $urandom_range(7);
                cfg.stride = ($urandom_range(99) < 80) ? $urandom_range(1, 4)
                                                       : $urandom_range(7);
                cfg.shift  = ($urandom_range(99) < 70) ? $urandom_range(4, 12)
                                                       : $urandom_range(31);
                cfg.mode   = $urandom_range(3);
            end
            apply_config(cfg);

            h = (cur_cfg.in_h > MAX_DIM) ? MAX_DIM : int'(cur_cfg.in_h);
            w = (cur_cfg.in_w > MAX_DIM) ? MAX_DIM : int'(cur_cfg.in_w);
            repeat ($urandom_range(40, 100))
            begin
                if (random_sent < RANDOM_ITEMS / 3)
                begin
                    send_idle_pct = 11;
                    recv_idle_pct = 71;
                end
                else if (random_sent < 2 * RANDOM_ITEMS / 3)
                begin
                    send_idle_pct = 71;
                    recv_idle_pct = 11;
                end
                else
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end

                pick = $urandom_range(99);
                if (pick < 8)
                begin
                    send_item(CMD_TAP, $urandom, $urandom,
                              ($urandom_range(99) < 80) ? $urandom_range(NTAPS - 1)
                                                        : $urandom_range(NTAPS, 15),
                              $urandom, $urandom, 1'b0, '0);
                    random_sent++;
                end
                else if (pick < 13)
                begin
                    pick = $urandom_range(99);
                    b = (pick < 15) ? 32'h7FFFFFFF : (pick < 30) ? 32'h80000000 : $urandom;
                    send_item(CMD_BIAS, $urandom, $urandom, $urandom, $urandom, b,
                              1'b0, '0);
                    random_sent++;
                end
                else if (pick < 40)
                begin
                    if (h == 0 || w == 0 || $urandom_range(99) < 10)
                    begin
                        r = $urandom_range(127);
                        c = $urandom_range(127);
                    end
                    else
                    begin
                        r = $urandom_range(h - 1);
                        c = $urandom_range(w - 1);
                    end
                    pixel_loaded[int'(r) * MAX_DIM + int'(c)] = 1'b1;
                    send_item(CMD_PIXEL, r, c, $urandom, $urandom, $urandom, 1'b0, '0);
                    random_sent++;
                end
                else
                begin
                    pick = $urandom_range(99);
                    if (pick < 8)
                    begin
                        r = cur_cfg.out_h - 8'd1;
                        c = cur_cfg.out_w - 8'd1;
                    end
                    else if (pick < 20 || cur_cfg.out_h == 0 || cur_cfg.out_w == 0)
                    begin
                        r = $urandom_range(127);
                        c = $urandom_range(127);
                    end
                    else
                    begin
                        r = $urandom_range((cur_cfg.out_h > MAX_DIM) ? MAX_DIM - 1
                                                                     : cur_cfg.out_h - 1);
                        c = $urandom_range((cur_cfg.out_w > MAX_DIM) ? MAX_DIM - 1
                                                                     : cur_cfg.out_w - 1);
                    end
                    send_compute(r, c);
                end
            end
            phase++;
        end

        wait_idle();
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
